>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and codes for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd1;

  // which candidate a cell keeps: t, t - m or t - 2m
  typedef enum logic [1:0] {
    SEL_T   = 2'd0,
    SEL_TM  = 2'd1,
    SEL_T2M = 2'd2
  } cell_sel_t;

  typedef struct packed {
    logic      clr;
    logic      en;
    cell_sel_t sel;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE_GO,
    ST_BASE_WT,
    ST_BIT,
    ST_MUL_GO,
    ST_MUL_WT,
    ST_NEXT,
    ST_SQR_GO,
    ST_SQR_WT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply base^exponent mod modulus over a bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_index/cfg_data written when cfg_valid && cfg_ready
//   (ready is always high). Index 0 = modulus (reset 2), 1 = exponent
//   (reset 1); other indexes are ignored. Write only while busy is low.
//   Request: in_base is taken when start is high and busy is low. busy
//   stays high until the result has been shown.
//   Result: out_power_mod is valid for exactly one cycle with out_valid;
//   the receiver cannot stall, so it must take it then.
//   Operation: a modular multiply is a launch, W cell steps with one
//   multiplier bit each, and a completion. A request runs one base
//   reduction, then per significant exponent bit a BIT step, a multiply
//   if the bit is set and a NEXT step, with a square between bits, and
//   ends in one done step. Exponent 0 (answers 1) and modulus 0 (answers
//   0) report in the cycle after the accept.
//   Requests are handled one at a time; the next one can be taken at the
//   end of the cycle after out_valid.
//   Reset (synchronous, rst_n low) returns to idle and restores the
//   register defaults; a request in flight is dropped.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [31:0]                      in_base,
  output logic                             out_valid,
  output logic [31:0]                      out_power_mod,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int unsigned W = OPERAND_WIDTH;

  mexp_pkg::state_t state_r, state_nxt;

  logic [W-1:0] modulus_r;
  logic [W-1:0] exponent_r;
  logic [W-1:0] base_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] sq_r;
  logic [W-1:0] exp_r;     // remaining exponent bits, LSB first
  logic [W-1:0] res_r;

  logic         mm_start;
  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic         mm_done;
  logic [W-1:0] mm_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(2);
      exponent_r <= W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_data[W-1:0];
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          if (exponent_r == '0 || modulus_r == '0) begin
            state_nxt = mexp_pkg::ST_DONE;
          end else begin
            state_nxt = mexp_pkg::ST_BASE_GO;
          end
        end
      end
      mexp_pkg::ST_BASE_GO: state_nxt = mexp_pkg::ST_BASE_WT;
      mexp_pkg::ST_BASE_WT: if (mm_done) state_nxt = mexp_pkg::ST_BIT;
      mexp_pkg::ST_BIT:     state_nxt = exp_r[0] ? mexp_pkg::ST_MUL_GO : mexp_pkg::ST_NEXT;
      mexp_pkg::ST_MUL_GO:  state_nxt = mexp_pkg::ST_MUL_WT;
      mexp_pkg::ST_MUL_WT:  if (mm_done) state_nxt = mexp_pkg::ST_NEXT;
      mexp_pkg::ST_NEXT:    state_nxt = (exp_r[W-1:1] == '0) ? mexp_pkg::ST_DONE
                                                           : mexp_pkg::ST_SQR_GO;
      mexp_pkg::ST_SQR_GO:  state_nxt = mexp_pkg::ST_SQR_WT;
      mexp_pkg::ST_SQR_WT:  if (mm_done) state_nxt = mexp_pkg::ST_BIT;
      mexp_pkg::ST_DONE:    state_nxt = mexp_pkg::ST_IDLE;
      default:              state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // outputs toward the multiplier and the ports
  always_comb begin
    mm_start = 1'b0;
    mm_a     = acc_r;
    mm_b     = sq_r;
    case (state_r)
      mexp_pkg::ST_BASE_GO: begin
        mm_start = 1'b1;
        mm_a     = W'(1);     // base * 1 mod m reduces the base
        mm_b     = base_r;
      end
      mexp_pkg::ST_MUL_GO: mm_start = 1'b1;
      mexp_pkg::ST_SQR_GO: begin
        mm_start = 1'b1;
        mm_a     = sq_r;
      end
      default: ;
    endcase
  end

  assign busy          = (state_r != mexp_pkg::ST_IDLE);
  assign out_valid     = (state_r == mexp_pkg::ST_DONE);
  assign out_power_mod = 32'(res_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        base_r <= in_base[W-1:0];
        exp_r  <= exponent_r;
        acc_r  <= (modulus_r == W'(1)) ? '0 : W'(1);
        // short answers for the degenerate cases
        res_r  <= (exponent_r == '0) ? W'(1) : '0;
      end
      mexp_pkg::ST_BASE_WT: if (mm_done) sq_r <= mm_res;
      mexp_pkg::ST_MUL_WT:  if (mm_done) acc_r <= mm_res;
      mexp_pkg::ST_SQR_WT:  if (mm_done) sq_r <= mm_res;
      mexp_pkg::ST_NEXT: begin
        exp_r <= {1'b0, exp_r[W-1:1]};
        res_r <= acc_r;
      end
      default: ;
    endcase
  end

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (modulus_r),
    .done   (mm_done),
    .result (mm_res)
  );

endmodule

>>> rtl/mexp_cell.sv
// ----------------------------------------------------------------------------
// mexp_cell
// One bit slice of the interleaved modular multiplier remainder.
// ----------------------------------------------------------------------------
module mexp_cell (
  input  logic                 clk,
  input  mexp_pkg::cell_ctrl_t ctrl,
  input  logic                 r_in,    // neighbor bit (doubling shift)
  input  logic                 a_bit,   // addend bit, already gated by b
  input  logic                 m_bit,
  input  logic                 m2_bit,  // bit of 2m
  input  logic                 c_in,
  input  logic                 b1_in,
  input  logic                 b2_in,
  output logic                 r_out,
  output logic                 c_out,
  output logic                 b1_out,
  output logic                 b2_out
);

  logic r_r;
  logic r_nxt;
  logic t_bit;
  logic d1_bit;
  logic d2_bit;

  assign t_bit  = r_in ^ a_bit ^ c_in;
  assign c_out  = (r_in & a_bit) | (r_in & c_in) | (a_bit & c_in);
  assign d1_bit = t_bit ^ m_bit ^ b1_in;
  assign b1_out = (~t_bit & m_bit) | (~(t_bit ^ m_bit) & b1_in);
  assign d2_bit = t_bit ^ m2_bit ^ b2_in;
  assign b2_out = (~t_bit & m2_bit) | (~(t_bit ^ m2_bit) & b2_in);

  always_comb begin
    case (ctrl.sel)
      mexp_pkg::SEL_TM:  r_nxt = d1_bit;
      mexp_pkg::SEL_T2M: r_nxt = d2_bit;
      default:           r_nxt = t_bit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      r_r <= 1'b0;
    end else if (ctrl.en) begin
      r_r <= r_nxt;
    end
  end

  assign r_out = r_r;

endmodule

>>> rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial a*b mod m over a row of remainder cells, one b bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int unsigned N  = W + 2;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [N:0]    c;
  logic [N:0]    bw1;
  logic [N:0]    bw2;
  logic [N-1:0]  r;
  logic [N-1:0]  a_ext;
  logic [N-1:0]  m_ext;
  logic [N-1:0]  m2_ext;
  mexp_pkg::cell_ctrl_t ctrl;

  assign a_ext  = b_r[W-1] ? {2'b00, a_r} : '0;
  assign m_ext  = {2'b00, m_r};
  assign m2_ext = {1'b0, m_r, 1'b0};
  assign c[0]   = 1'b0;
  assign bw1[0] = 1'b0;
  assign bw2[0] = 1'b0;

  // no final borrow means t >= that multiple of m
  always_comb begin
    ctrl.clr = start;
    ctrl.en  = busy_r;
    if (!bw2[N]) begin
      ctrl.sel = mexp_pkg::SEL_T2M;
    end else if (!bw1[N]) begin
      ctrl.sel = mexp_pkg::SEL_TM;
    end else begin
      ctrl.sel = mexp_pkg::SEL_T;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    mexp_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .r_in   ((i == 0) ? 1'b0 : r[(i == 0) ? 0 : i-1]),
      .a_bit  (a_ext[i]),
      .m_bit  (m_ext[i]),
      .m2_bit (m2_ext[i]),
      .c_in   (c[i]),
      .b1_in  (bw1[i]),
      .b2_in  (bw2[i]),
      .r_out  (r[i]),
      .c_out  (c[i+1]),
      .b1_out (bw1[i+1]),
      .b2_out (bw2[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      m_r <= m;
    end else if (busy_r) begin
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = r[W-1:0];

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mulmod done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("mulmod did not start");
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && (m_r != '0) && (a_r < m_r || m_r == W'(1))) |-> (r[W-1:0] < m_r))
    else $error("mulmod result not reduced");
`endif

endmodule

>>> test/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench: directed and random bases under several modulus and
// exponent settings, each result compared with a square-and-multiply predictor or a typed-in value.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  localparam int unsigned OP_W      = 32;
  localparam int          N_RANDOM  = 1300;
  localparam int          WATCHDOG  = 200000;
  // worst request: 32 exponent bits all set
  localparam int          DRAIN_CYC = 2400;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_base;
  logic        out_valid;
  logic [31:0] out_power_mod;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the two registers
  logic [31:0] cur_modulus;
  logic [31:0] cur_exponent;

  logic [31:0] pending_powers[$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  int          idle_cycles;

  modular_exponentiation #(.OPERAND_WIDTH(OP_W)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_base(in_base),
    .out_valid(out_valid), .out_power_mod(out_power_mod),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // square-and-multiply over 64-bit products
  function automatic logic [31:0] predict_power(input logic [31:0] b,
                                                input logic [31:0] e,
                                                input logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [31:0] rest;
    if (e == 0) return 32'd1;
    if (m == 0) return 32'd0;
    rest = e;
    acc  = 64'd1 % m;
    sq   = {32'd0, b} % m;
    while (rest != 0) begin
      if (rest[0]) acc = (acc * sq) % m;
      rest = rest >> 1;
      if (rest != 0) sq = (sq * sq) % m;
    end
    return acc[31:0];
  endfunction

  // result checker; results cannot be stalled so sample every edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (pending_powers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result %h", out_power_mod);
      end else begin
        if (out_power_mod !== pending_powers[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("power_mod mismatch: expected %h got %h",
                     pending_powers[0], out_power_mod);
        end
        void'(pending_powers.pop_front());
      end
    end
  end

  // watchdog: cycles with no accepted request, register write or result
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // the shortest gap is no longer than the block stays busy after an accept anyway
  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 3) == 0) n = 1;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 80);
    else n = $urandom_range(1, 4);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mexp_pkg::REG_MODULUS) cur_modulus = val;
    else if (idx == mexp_pkg::REG_EXPONENT) cur_exponent = val;
    @(posedge clk);
  endtask

  // send one request; a typed-in value overrides the predictor
  task automatic send_base(input logic [31:0] b, input bit typed,
                           input logic [31:0] typed_val);
    start   <= 1'b1;
    in_base <= b;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    pending_powers.push_back(typed ? typed_val :
                             predict_power(b, cur_exponent, cur_modulus));
    requests_sent++;
    idle_gap();
  endtask

  task automatic drain();
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  typedef struct {
    bit          wr;       // row writes a register instead of sending
    logic [mexp_pkg::CFG_INDEX_W-1:0] idx;
    logic [31:0] val;      // register data or base
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  stim_row_t plan[] = '{
    // reset: modulus 2, exponent 1 -> parity of base
    '{0, mexp_pkg::REG_MODULUS, 32'd0,          1, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFF,  1, 32'd1},
    '{0, mexp_pkg::REG_MODULUS, 32'd7,          1, 32'd1},
    // zero exponent answers one, even with modulus zero
    '{1, mexp_pkg::REG_EXPONENT, 32'd0,         0, 32'd0},
    '{1, mexp_pkg::REG_MODULUS, 32'd0,          0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFF,  1, 32'd1},
    '{0, mexp_pkg::REG_MODULUS, 32'd0,          1, 32'd1},
    // modulus zero, nonzero exponent answers zero
    '{1, mexp_pkg::REG_EXPONENT, 32'hFFFF_FFFF, 0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'd12345,      1, 32'd0},
    // modulus one answers zero
    '{1, mexp_pkg::REG_MODULUS, 32'd1,          0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFF,  1, 32'd0},
    // unknown index is ignored
    '{1, 2'd3,                  32'd99,         0, 32'd0},
    '{1, 2'd2,                  32'd99,         0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'd5,          1, 32'd0},
    // max modulus, max exponent
    '{1, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFF,  0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFE,  0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'hFFFF_FFFF,  1, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'd0,          0, 32'd0},
    // small RSA-like pair
    '{1, mexp_pkg::REG_MODULUS, 32'd3233,       0, 32'd0},
    '{1, mexp_pkg::REG_EXPONENT, 32'd17,        0, 32'd0},
    '{0, mexp_pkg::REG_MODULUS, 32'd65,         1, 32'd2790},
    '{0, mexp_pkg::REG_MODULUS, 32'h8000_0000,  0, 32'd0}
  };

  initial begin
    logic [31:0] mod_pick;
    logic [31:0] exp_pick;
    int          phase;
    int          n;
    start = 1'b0; in_base = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cur_modulus = 32'd2; cur_exponent = 32'd1;
    mismatches = 0; results_seen = 0; requests_sent = 0; idle_cycles = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_base(plan[i].val, plan[i].typed, plan[i].want);
      end
    end

    // random phases; mostly short exponents, a few full-width
    phase = 0;
    while (requests_sent < N_RANDOM + plan.size()) begin
      drain();
      case ($urandom_range(0, 5))
        0: mod_pick = $urandom_range(0, 3);
        1: mod_pick = 32'hFFFF_FFFF - $urandom_range(0, 3);
        2: mod_pick = $urandom_range(2, 1000);
        default: mod_pick = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: exp_pick = $urandom_range(0, 2);
        1: exp_pick = 32'hFFFF_FFFF;
        2: exp_pick = $urandom;
        3: exp_pick = 32'h8000_0000 | $urandom_range(0, 7);
        default: exp_pick = $urandom_range(0, 255);
      endcase
      write_reg(mexp_pkg::REG_MODULUS, mod_pick);
      write_reg(mexp_pkg::REG_EXPONENT, exp_pick);
      if ($urandom_range(0, 9) == 0)
        write_reg(mexp_pkg::CFG_INDEX_W'($urandom_range(2, 3)), $urandom);
      n = (exp_pick > 32'hFFFF) ? $urandom_range(5, 15) : $urandom_range(20, 60);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: send_base(32'd0, 0, '0);
          1: send_base(32'hFFFF_FFFF, 0, '0);
          2: send_base(mod_pick + $urandom_range(0, 2) - 1, 0, '0);
          default: send_base($urandom, 0, '0);
        endcase
      end
      phase++;
    end

    drain();
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d requests over %0d register settings plus directed rows",
             requests_sent, phase);
    $display("%0d results checked, %0d left waiting", results_seen,
             pending_powers.size());
    if (mismatches == 0 && pending_powers.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
